[rtl/glyph_dilate_and_shear_macros.svh]
// assertion macros for the glyph dilate and shear block
// expects clk and rst_n in the scope of each use
`ifndef GLYPH_DILATE_AND_SHEAR_MACROS_SVH
`define GLYPH_DILATE_AND_SHEAR_MACROS_SVH

// same-cycle implication
`define GDS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GDS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/gds_pkg.sv]
// shared constants, register codes and controller/datapath structs
// used by gds_ctrl, gds_datapath and glyph_dilate_and_shear; no dependencies
package gds_pkg;

    localparam int MAX_WIDTH       = 32;
    localparam int MAX_HEIGHT      = 64;
    localparam int MAX_SPREAD      = 8;
    localparam int SLANT_FRAC_BITS = 8;
    localparam int SLANT_LIMIT     = 64;

    localparam int PIX_W      = 8;
    localparam int WCFG_W     = 6;
    localparam int HCFG_W     = 7;
    localparam int BASE_W     = 8;
    localparam int SPREAD_W   = 4;
    localparam int SLANT_W    = 8;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 3;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int OUTCOL_W = 6;
    localparam int SHIFT_W  = 7;
    localparam int WIDEN_W  = 5;
    localparam int DIFF_W   = BASE_W + 1;
    localparam int PROD_W   = SLANT_W + DIFF_W;
    localparam int ABS_W    = SLANT_W - 1;
    localparam int AH_W     = ABS_W + HCFG_W;
    localparam int TGT_W    = 8;

    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DILATE_SPREAD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLANT_Q8        = 3'd4;

    typedef struct packed {
        logic take;
        logic setup;
        logic plan;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic emit_any;
        logic last_emit;
    } status_t;

endpackage

[rtl/gds_ctrl.sv]
// sequencing state machine: accept, row setup, emission plan, result emission
// depends on gds_pkg and glyph_dilate_and_shear_macros.svh
`include "glyph_dilate_and_shear_macros.svh"

module gds_ctrl
    import gds_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_PLAN,
        S_EMIT
    } state_t;

    state_t state_reg;
    logic   in_stall_reg;
    logic   out_valid_reg;

    assign in_stall  = in_stall_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.take   = (state_reg == S_IDLE) && in_valid;
        cmd.setup  = (state_reg == S_SETUP);
        cmd.plan   = (state_reg == S_PLAN);
        cmd.step   = out_valid_reg && !out_stall;
        cmd.finish = ((state_reg == S_PLAN) && !status.emit_any)
                   || (out_valid_reg && !out_stall && status.last_emit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_stall_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg    <= S_SETUP;
                        in_stall_reg <= 1'b1;
                    end
                end
                S_SETUP:
                begin
                    state_reg <= S_PLAN;
                end
                S_PLAN:
                begin
                    if (status.emit_any)
                    begin
                        state_reg     <= S_EMIT;
                        out_valid_reg <= 1'b1;
                    end
                    else
                    begin
                        state_reg    <= S_IDLE;
                        in_stall_reg <= 1'b0;
                    end
                end
                S_EMIT:
                begin
                    if (!out_stall && status.last_emit)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b0;
                        in_stall_reg  <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `GDS_ASSERT_IMP(a_no_request_while_result, out_valid_reg, in_stall_reg, "request taken with result pending")
    `GDS_ASSERT_NXT(a_take_busy, cmd.take, in_stall_reg && !out_valid_reg, "accept did not start work")
    `GDS_ASSERT_NXT(a_last_frees, cmd.step && status.last_emit, !out_valid_reg && !in_stall_reg, "last result did not free block")

endmodule

[rtl/gds_datapath.sv]
// configuration registers, dilation window, shear arithmetic and output columns
// depends on gds_pkg; driven by gds_ctrl commands
module gds_datapath
    import gds_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [PIX_W-1:0]      pixel_in,
    input  cmd_t                  cmd,
    output status_t               status,
    output logic [PIX_W-1:0]      pixel_out,
    output logic                  last_of_run,
    output logic                  row_done,
    output logic                  glyph_done
);

    localparam logic signed [SLANT_W-1:0] SLANT_MAX = SLANT_W'(SLANT_LIMIT);
    localparam logic signed [SLANT_W-1:0] SLANT_MIN = SLANT_W'(-SLANT_LIMIT);

    logic        [WCFG_W-1:0]   width_reg;
    logic        [HCFG_W-1:0]   height_reg;
    logic signed [BASE_W-1:0]   base_reg;
    logic        [SPREAD_W-1:0] spread_reg;
    logic signed [SLANT_W-1:0]  slant_reg;

    logic [ROW_W-1:0]    row_reg;
    logic [COL_W-1:0]    col_reg;
    logic [PIX_W-1:0]    win_reg [MAX_SPREAD];
    logic [OUTCOL_W-1:0] next_reg;
    logic [SHIFT_W-1:0]  shift_reg;
    logic [WIDEN_W-1:0]  widen_reg;
    logic                start_reg;
    logic                hit_reg;

    logic [PIX_W-1:0]    v_reg;
    logic [PROD_W-1:0]   p_reg;
    logic [AH_W-1:0]     ah_reg;
    logic [OUTCOL_W-1:0] tgt_reg;
    logic [OUTCOL_W-1:0] end_reg;

    logic        [WCFG_W-1:0]   w_eff;
    logic        [HCFG_W-1:0]   h_eff;
    logic        [SPREAD_W-1:0] spread_eff;
    logic signed [SLANT_W-1:0]  slant_eff;

    logic                     row_start;
    logic [PIX_W-1:0]         win_eff [MAX_SPREAD];
    logic [PIX_W-1:0]         win_next [MAX_SPREAD];
    logic [PIX_W-1:0]         dil;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] slant_x;
    logic signed [PROD_W-1:0] diff_x;
    logic [ABS_W-1:0]         slant_abs;

    logic                p_neg;
    logic [PROD_W-1:0]   p_mag;
    logic [PROD_W:0]     rnd_sum;
    logic [SHIFT_W-1:0]  r_mag;
    logic [SHIFT_W-1:0]  shift_val;
    logic [AH_W:0]       wsum;
    logic [WIDEN_W-1:0]  wq;
    logic [WIDEN_W-1:0]  widen_val;

    logic [OUTCOL_W-1:0] total;
    logic [TGT_W-1:0]    target;
    logic                hit;
    logic                last_col;
    logic                last_row;
    logic [OUTCOL_W-1:0] end_val;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = WCFG_W'(1);
        else if (width_reg > WCFG_W'(MAX_WIDTH))
            w_eff = WCFG_W'(MAX_WIDTH);
        else
            w_eff = width_reg;

        if (height_reg == '0)
            h_eff = HCFG_W'(1);
        else if (height_reg > HCFG_W'(MAX_HEIGHT))
            h_eff = HCFG_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;

        if (spread_reg > SPREAD_W'(MAX_SPREAD))
            spread_eff = SPREAD_W'(MAX_SPREAD);
        else
            spread_eff = spread_reg;

        if (slant_reg > SLANT_MAX)
            slant_eff = SLANT_MAX;
        else if (slant_reg < SLANT_MIN)
            slant_eff = SLANT_MIN;
        else
            slant_eff = slant_reg;
    end

    // dilation window, history cleared at row start
    always_comb
    begin
        row_start = (col_reg == '0);
        for (int i = 0; i < MAX_SPREAD; i++)
            win_eff[i] = row_start ? '0 : win_reg[i];
        dil = pixel_in;
        for (int i = 0; i < MAX_SPREAD; i++)
            if ((SPREAD_W'(i) < spread_eff) && (win_eff[i] > dil))
                dil = win_eff[i];
        win_next[0] = pixel_in;
        for (int i = 1; i < MAX_SPREAD; i++)
            win_next[i] = win_eff[i-1];
    end

    always_comb
    begin
        diff      = $signed({base_reg[BASE_W-1], base_reg})
                  - $signed({{(DIFF_W-ROW_W){1'b0}}, row_reg});
        slant_x   = PROD_W'(slant_eff);
        diff_x    = PROD_W'(diff);
        slant_abs = slant_eff[SLANT_W-1] ? ABS_W'(-slant_eff) : slant_eff[ABS_W-1:0];
    end

    // rounding half away from zero and widening ceiling
    always_comb
    begin
        p_neg     = p_reg[PROD_W-1];
        p_mag     = p_neg ? (~p_reg + PROD_W'(1)) : p_reg;
        rnd_sum   = {1'b0, p_mag} + (PROD_W+1)'(1 << (SLANT_FRAC_BITS - 1));
        r_mag     = rnd_sum[SLANT_FRAC_BITS +: SHIFT_W];
        shift_val = p_neg ? (~r_mag + SHIFT_W'(1)) : r_mag;
        wsum      = {1'b0, ah_reg} + (AH_W+1)'((1 << SLANT_FRAC_BITS) - 1);
        wq        = wsum[SLANT_FRAC_BITS +: WIDEN_W];
        if (slant_eff == '0)
            widen_val = '0;
        else if (wq == '0)
            widen_val = WIDEN_W'(1);
        else
            widen_val = wq;
    end

    always_comb
    begin
        total    = OUTCOL_W'(w_eff) + OUTCOL_W'(widen_reg);
        target   = TGT_W'({{(TGT_W-COL_W){1'b0}}, col_reg})
                 + TGT_W'({{(TGT_W-SHIFT_W){shift_reg[SHIFT_W-1]}}, shift_reg});
        hit      = !target[TGT_W-1]
                 && (target[TGT_W-2:0] < {1'b0, total})
                 && (target[TGT_W-2:0] >= {1'b0, next_reg});
        last_col = ({1'b0, col_reg} + WCFG_W'(1)) >= w_eff;
        last_row = ({1'b0, row_reg} + HCFG_W'(1)) >= h_eff;
        if (last_col)
            end_val = total;
        else if (hit)
            end_val = target[OUTCOL_W-1:0] + OUTCOL_W'(1);
        else
            end_val = next_reg;
        status.emit_any  = end_val > next_reg;
        status.last_emit = (next_reg + OUTCOL_W'(1)) == end_reg;
    end

    always_comb
    begin
        pixel_out   = (hit_reg && (next_reg == tgt_reg)) ? v_reg : '0;
        row_done    = (next_reg + OUTCOL_W'(1)) == total;
        glyph_done  = row_done && last_row;
        last_of_run = status.last_emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WCFG_W'(1);
            height_reg <= HCFG_W'(1);
            base_reg   <= '0;
            spread_reg <= '0;
            slant_reg  <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_GLYPH_WIDTH:     width_reg  <= cfg_data[WCFG_W-1:0];
                REG_GLYPH_HEIGHT:    height_reg <= cfg_data[HCFG_W-1:0];
                REG_BASELINE_OFFSET: base_reg   <= cfg_data[BASE_W-1:0];
                REG_DILATE_SPREAD:   spread_reg <= cfg_data[SPREAD_W-1:0];
                REG_SLANT_Q8:        slant_reg  <= cfg_data[SLANT_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            col_reg   <= '0;
            next_reg  <= '0;
            shift_reg <= '0;
            widen_reg <= '0;
            start_reg <= 1'b0;
            hit_reg   <= 1'b0;
            for (int i = 0; i < MAX_SPREAD; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            if (cmd.take)
            begin
                start_reg <= row_start;
                for (int i = 0; i < MAX_SPREAD; i++)
                    win_reg[i] <= win_next[i];
            end
            if (cmd.setup && start_reg)
            begin
                shift_reg <= shift_val;
                widen_reg <= widen_val;
                next_reg  <= '0;
            end
            if (cmd.plan)
                hit_reg <= hit;
            if (cmd.step)
                next_reg <= next_reg + OUTCOL_W'(1);
            if (cmd.finish)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            v_reg  <= dil;
            p_reg  <= PROD_W'(slant_x * diff_x);
            ah_reg <= AH_W'(slant_abs) * AH_W'(h_eff);
        end
        if (cmd.plan)
        begin
            tgt_reg <= target[OUTCOL_W-1:0];
            end_reg <= end_val;
        end
    end

endmodule

[rtl/glyph_dilate_and_shear.sv]
// top level of the glyph dilate and shear block
// depends on gds_pkg, gds_ctrl and gds_datapath
//
// Coverage pixels enter in raster order, one request at a time. Each accepted
// pixel is taken in the idle state, then passes through row setup (shear shift
// and widening, from the product registered at accept) and planning of its
// output columns, then emits its results one per cycle while out_stall is low.
// A pixel yields from 0 to glyph_width + widening results, and the block takes
// no new pixel until its last result is out. Configuration is written through
// cfg_write_en, cfg_index and cfg_data; the user must write it only while no
// pixel is in flight, as the block itself does not enforce this.
module glyph_dilate_and_shear
    import gds_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIX_W-1:0]      pixel_in,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PIX_W-1:0]      pixel_out,
    output logic                  last_of_run,
    output logic                  row_done,
    output logic                  glyph_done
);

    cmd_t    cmd;
    status_t status;

    gds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    gds_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_in     (pixel_in),
        .cmd          (cmd),
        .status       (status),
        .pixel_out    (pixel_out),
        .last_of_run  (last_of_run),
        .row_done     (row_done),
        .glyph_done   (glyph_done)
    );

endmodule
